// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent in a cycle requires the consequent in the same cycle.
`define CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The antecedent in a cycle requires the consequent in the next cycle.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/tcab_pkg.sv =====
`timescale 1ns / 1ps
// Package for the text cell alpha blit: stage counts, codes, types and the
// arithmetic helpers used by the blend pipeline. Depends on nothing.
package tcab_pkg;

	localparam int GLYPH_W   = 21;
	localparam int RGBA_W    = 32;
	localparam int N_W       = 18;
	localparam int BLEND_STG = 9;
	localparam int BG_FIRST  = 2;
	localparam int BG_LAST   = BG_FIRST + BLEND_STG - 1;
	localparam int FG_FIRST  = BG_LAST + 1;
	localparam int FG_LAST   = FG_FIRST + BLEND_STG - 1;
	localparam int NSTG      = FG_LAST + 1;

	localparam logic [GLYPH_W-1:0] SPACE_GLYPH  = 21'd32;
	localparam logic [16:0]        OPAQUE_LIMIT = 17'd65152;
	localparam logic [16:0]        HALF_POINT   = 17'd32640;
	localparam logic [N_W-1:0]     ALPHA_DEN    = 18'd65280;

	typedef enum logic [1:0] {
		REG_FG_FACTOR = 2'd0,
		REG_BG_FACTOR = 2'd1,
		REG_KEY_EN    = 2'd2,
		REG_KEY_RGB   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_COPY  = 2'd1,
		MODE_BLEND = 2'd2
	} mode_t;

	// Cell data carried beside the background blend.
	typedef struct packed {
		mode_t              mode;
		logic [GLYPH_W-1:0] glyph;
		logic [RGBA_W-1:0]  fore;
		logic [RGBA_W-1:0]  back;
		logic               fg_dst_ob;
		logic               fg_src_ob;
		logic [RGBA_W-1:0]  fdst;
		logic [RGBA_W-1:0]  fsrc;
		logic [N_W-1:0]     fn;
	} side_t;

	// Cell data carried beside the foreground blend.
	typedef struct packed {
		mode_t              mode;
		logic [GLYPH_W-1:0] glyph;
		logic [RGBA_W-1:0]  fore;
		logic [RGBA_W-1:0]  back;
	} cell_t;

	// Exact floor(x / 255): reciprocal estimate that is low by at most one,
	// then one compare against the remainder.
	function automatic logic [16:0] div255(input logic [23:0] x);
		logic [40:0] acc;
		logic [16:0] q0;
		logic [24:0] r;
		acc = {17'd0, x} + {9'd0, x, 8'd0} + {1'b0, x, 16'd0};
		q0  = acc[40:24];
		r   = {1'b0, x} + {8'd0, q0} - {q0, 8'd0};
		return (r >= 25'd255) ? q0 + 17'd1 : q0;
	endfunction

	// Two restoring division steps for quotient bits k+1 and k.
	// Returns {bit k+1, bit k, remainder}.
	function automatic logic [18:0] div_step2(input logic [16:0] rem, input logic [7:0] d,
			input logic [2:0] k);
		logic [16:0] dh;
		logic [16:0] dl;
		logic [16:0] r;
		logic        bh;
		logic        bl;
		dh = 17'(d) << (k + 3'd1);
		dl = 17'(d) << k;
		bh = (rem >= dh);
		r  = bh ? rem - dh : rem;
		bl = (r >= dl);
		r  = bl ? r - dl : r;
		return {bh, bl, r};
	endfunction

endpackage

// ===== src/tcab_blend.sv =====
`timescale 1ns / 1ps
// Nine-stage pipelined source-over blend of two RGBA colors with weight n.
// Depends on tcab_pkg for widths and the divide helpers.
module tcab_blend (
	input  logic                          clk,
	input  logic [tcab_pkg::BLEND_STG-1:0] en,
	input  logic [tcab_pkg::RGBA_W-1:0]   dst,
	input  logic [tcab_pkg::RGBA_W-1:0]   src,
	input  logic [tcab_pkg::N_W-1:0]      n,
	output logic [tcab_pkg::RGBA_W-1:0]   res
);
	import tcab_pkg::*;

	logic [15:0] t_s1;
	logic [25:0] p_s1;
	logic [7:0]  sa_s1, da_s1;
	logic [23:0] sc_s1, dc_s1;
	logic [31:0] dst_s1;

	logic [7:0]  oa_s2, s_s2, da_s2;
	logic [23:0] sc_s2, dc_s2;
	logic [31:0] dst_s2;

	logic [15:0] m_s3 [3];
	logic [15:0] ss_s3 [3];
	logic [7:0]  ns_s3, oa_s3;
	logic [31:0] dst_s3;

	logic [23:0] w_s4 [3];
	logic [15:0] ss_s4 [3];
	logic [7:0]  oa_s4;
	logic [31:0] dst_s4;

	logic [16:0] num_s5 [3];
	logic [7:0]  oa_s5;
	logic [31:0] dst_s5;

	logic [16:0] rem_s6 [3], rem_s7 [3], rem_s8 [3];
	logic [7:0]  q_s6 [3], q_s7 [3], q_s8 [3];
	logic        sat_s6 [3], sat_s7 [3], sat_s8 [3];
	logic [7:0]  oa_s6, oa_s7, oa_s8;
	logic [31:0] dst_s6, dst_s7, dst_s8;

	logic [16:0] tdiv, sdiv;
	logic [16:0] wdiv [3];
	logic [18:0] st6 [3], st7 [3], st8 [3], st9 [3];
	logic [7:0]  chan [3];

	always_comb begin
		tdiv = div255({8'd0, t_s1});
		sdiv = div255({6'd0, p_s1[25:8]});
		for (int c = 0; c < 3; c++) begin
			wdiv[c] = div255(w_s4[c]);
			st6[c]  = div_step2(num_s5[c], oa_s5, 3'd6);
			st7[c]  = div_step2(rem_s6[c], oa_s6, 3'd4);
			st8[c]  = div_step2(rem_s7[c], oa_s7, 3'd2);
			st9[c]  = div_step2(rem_s8[c], oa_s8, 3'd0);
			chan[c] = sat_s8[c] ? 8'hFF : {q_s8[c][7:2], st9[c][18:17]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1   <= 16'(dst[7:0]) * 16'(8'd255 - src[7:0]);
			p_s1   <= 26'(src[7:0]) * 26'(n);
			sa_s1  <= src[7:0];
			da_s1  <= dst[7:0];
			sc_s1  <= src[31:8];
			dc_s1  <= dst[31:8];
			dst_s1 <= dst;
		end
		if (en[1]) begin
			oa_s2  <= sa_s1 + tdiv[7:0];
			s_s2   <= (sdiv > 17'd255) ? 8'hFF : sdiv[7:0];
			da_s2  <= da_s1;
			sc_s2  <= sc_s1;
			dc_s2  <= dc_s1;
			dst_s2 <= dst_s1;
		end
		if (en[2]) begin
			for (int c = 0; c < 3; c++) begin
				m_s3[c]  <= 16'(dc_s2[8*c +: 8]) * 16'(da_s2);
				ss_s3[c] <= 16'(sc_s2[8*c +: 8]) * 16'(s_s2);
			end
			ns_s3  <= 8'd255 - s_s2;
			oa_s3  <= oa_s2;
			dst_s3 <= dst_s2;
		end
		if (en[3]) begin
			for (int c = 0; c < 3; c++) begin
				w_s4[c]  <= 24'(m_s3[c]) * 24'(ns_s3);
				ss_s4[c] <= ss_s3[c];
			end
			oa_s4  <= oa_s3;
			dst_s4 <= dst_s3;
		end
		if (en[4]) begin
			for (int c = 0; c < 3; c++)
				num_s5[c] <= {1'b0, ss_s4[c]} + wdiv[c];
			oa_s5  <= oa_s4;
			dst_s5 <= dst_s4;
		end
		if (en[5]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s6[c] <= (num_s5[c] >= {1'b0, oa_s5, 8'd0});
				rem_s6[c] <= st6[c][16:0];
				q_s6[c]   <= {st6[c][18:17], 6'd0};
			end
			oa_s6  <= oa_s5;
			dst_s6 <= dst_s5;
		end
		if (en[6]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s7[c] <= sat_s6[c];
				rem_s7[c] <= st7[c][16:0];
				q_s7[c]   <= {q_s6[c][7:6], st7[c][18:17], 4'd0};
			end
			oa_s7  <= oa_s6;
			dst_s7 <= dst_s6;
		end
		if (en[7]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s8[c] <= sat_s7[c];
				rem_s8[c] <= st8[c][16:0];
				q_s8[c]   <= {q_s7[c][7:4], st8[c][18:17], 2'd0};
			end
			oa_s8  <= oa_s7;
			dst_s8 <= dst_s7;
		end
		if (en[8]) begin
			// A zero output alpha keeps the destination color untouched.
			res <= (oa_s8 == 8'd0) ? dst_s8 : {chan[2], chan[1], chan[0], oa_s8};
		end
	end

endmodule

// ===== src/text_cell_alpha_blit.sv =====
`timescale 1ns / 1ps
// Top level of the text cell alpha blit: config registers, cell decisions,
// two blend pipelines in series and the output register. Uses tcab_pkg, tcab_blend.
//
//  Channel  | Direction | Signals                                  | Transaction
//  ---------+-----------+------------------------------------------+------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[175:0]        | one source/dest cell pair
//  m_axis   | out       | m_axis_tvalid/tready/tdata[87:0]         | one resulting cell
//  cfg      | in        | cfg_valid/ready, cfg_index, cfg_data     | one register write
//
// Throughput is one cell per clock cycle while m_axis_tready is high; the result
// sits in the output register, the last of 20 register stages (input stage, two
// nine-stage blend pipelines with their divider steps, output stage).
// arst_n clears all valid bits and sets the config registers to their reset values.
// Every stage keeps its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up and a stall at the output holds data
// in place without losing or repeating a cell.
module text_cell_alpha_blit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// src_glyph[20:0], src_fore[52:21], src_back[84:53], dst_glyph[105:85],
	// dst_fore[137:106], dst_back[169:138], zero fill [175:170]
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_glyph[20:0], out_fore[52:21], out_back[84:53], zero fill [87:85]
	output logic [87:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import tcab_pkg::*;

	// Configuration registers.
	logic [8:0]  fg_factor_q, bg_factor_q;
	logic        key_en_q;
	logic [23:0] key_rgb_q;

	// Handshake chain: en[k] loads stage k.
	logic [NSTG+1:1] en;
	logic [NSTG:1]   vld_q;

	// Input stage.
	logic [GLYPH_W-1:0] sg_s1, dg_s1;
	logic [RGBA_W-1:0]  sf_s1, sb_s1, df_s1, db_s1;
	logic [16:0]        fgn_s1, bgn_s1;

	side_t side_d;
	side_t side_s [BG_FIRST:BG_LAST];
	cell_t cell_d;
	cell_t cell_s [FG_FIRST:FG_LAST];

	logic [RGBA_W-1:0] bg_res, fg_res, fg_dst, fg_src;

	logic [GLYPH_W-1:0] og_s20;
	logic [RGBA_W-1:0]  of_s20, ob_s20;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_factor_q <= 9'd256;
			bg_factor_q <= 9'd256;
			key_en_q    <= 1'b0;
			key_rgb_q   <= 24'd0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FG_FACTOR: fg_factor_q <= cfg_data[8:0];
				REG_BG_FACTOR: bg_factor_q <= cfg_data[8:0];
				REG_KEY_EN:    key_en_q    <= cfg_data[0];
				REG_KEY_RGB:   key_rgb_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on this edge.
	always_comb begin
		en[NSTG+1] = m_axis_tready;
		for (int k = NSTG; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// The effective alpha products are formed on the way into the first stage.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sg_s1  <= s_axis_tdata[20:0];
			sf_s1  <= s_axis_tdata[52:21];
			sb_s1  <= s_axis_tdata[84:53];
			dg_s1  <= s_axis_tdata[105:85];
			df_s1  <= s_axis_tdata[137:106];
			db_s1  <= s_axis_tdata[169:138];
			fgn_s1 <= 17'(fg_factor_q) * 17'(s_axis_tdata[28:21]);
			bgn_s1 <= 17'(bg_factor_q) * 17'(s_axis_tdata[60:53]);
		end
	end

	// Cell decision. A key hit passes the destination, two opaque alphas copy
	// the source; otherwise the background always blends and the foreground
	// blend takes its operands by the glyph rules. Where a foreground operand
	// is the blended background, a flag picks it up once that result exists.
	always_comb begin
		side_d.mode      = MODE_PASS;
		side_d.glyph     = dg_s1;
		side_d.fore      = df_s1;
		side_d.back      = db_s1;
		side_d.fg_dst_ob = 1'b0;
		side_d.fg_src_ob = 1'b0;
		side_d.fdst      = df_s1;
		side_d.fsrc      = sf_s1;
		side_d.fn        = {1'b0, fgn_s1};
		if (key_en_q && (sb_s1[31:8] == key_rgb_q)) begin
			side_d.mode = MODE_PASS;
		end else if ((fgn_s1 > OPAQUE_LIMIT) && (bgn_s1 > OPAQUE_LIMIT)) begin
			side_d.mode  = MODE_COPY;
			side_d.glyph = sg_s1;
			side_d.fore  = sf_s1;
			side_d.back  = sb_s1;
		end else begin
			side_d.mode = MODE_BLEND;
			if (sg_s1 == SPACE_GLYPH) begin
				// Space over anything: the foreground fades toward the new background.
				side_d.fsrc = sb_s1;
				side_d.fn   = {1'b0, bgn_s1};
			end else if (dg_s1 == SPACE_GLYPH) begin
				side_d.glyph     = sg_s1;
				side_d.fg_dst_ob = 1'b1;
			end else if (dg_s1 == sg_s1) begin
				side_d.fn = {1'b0, fgn_s1};
			end else if (fgn_s1 < HALF_POINT) begin
				// First half of a crossfade: the old glyph fades out.
				side_d.fg_src_ob = 1'b1;
				side_d.fn        = {fgn_s1, 1'b0};
			end else begin
				// Second half: the new glyph fades in over the new background.
				side_d.glyph     = sg_s1;
				side_d.fg_dst_ob = 1'b1;
				side_d.fn        = {fgn_s1, 1'b0} - ALPHA_DEN;
			end
		end
	end

	tcab_blend u_bg_blend (
		.clk (clk),
		.en  (en[BG_LAST:BG_FIRST]),
		.dst (db_s1),
		.src (sb_s1),
		.n   ({1'b0, bgn_s1}),
		.res (bg_res)
	);

	always_ff @(posedge clk) begin
		if (en[BG_FIRST])
			side_s[BG_FIRST] <= side_d;
		for (int k = BG_FIRST + 1; k <= BG_LAST; k++)
			if (en[k])
				side_s[k] <= side_s[k-1];
	end

	// The background result is ready here; route it into the foreground blend.
	always_comb begin
		fg_dst     = side_s[BG_LAST].fg_dst_ob ? bg_res : side_s[BG_LAST].fdst;
		fg_src     = side_s[BG_LAST].fg_src_ob ? bg_res : side_s[BG_LAST].fsrc;
		cell_d.mode  = side_s[BG_LAST].mode;
		cell_d.glyph = side_s[BG_LAST].glyph;
		cell_d.fore  = side_s[BG_LAST].fore;
		cell_d.back  = (side_s[BG_LAST].mode == MODE_BLEND) ? bg_res : side_s[BG_LAST].back;
	end

	tcab_blend u_fg_blend (
		.clk (clk),
		.en  (en[FG_LAST:FG_FIRST]),
		.dst (fg_dst),
		.src (fg_src),
		.n   (side_s[BG_LAST].fn),
		.res (fg_res)
	);

	always_ff @(posedge clk) begin
		if (en[FG_FIRST])
			cell_s[FG_FIRST] <= cell_d;
		for (int k = FG_FIRST + 1; k <= FG_LAST; k++)
			if (en[k])
				cell_s[k] <= cell_s[k-1];
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			og_s20 <= cell_s[FG_LAST].glyph;
			of_s20 <= (cell_s[FG_LAST].mode == MODE_BLEND) ? fg_res : cell_s[FG_LAST].fore;
			ob_s20 <= cell_s[FG_LAST].back;
		end
	end

	assign m_axis_tdata = {3'd0, ob_s20, of_s20, og_s20};

endmodule

// ===== src/tcab_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the text cell alpha blit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tcab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic        cfg_ready
);
	`CHK_NEXT(a_out_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`CHK_NEXT(a_out_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// With the output side free every stage moves, so the input side is open.
	`CHK_SAME(a_ready_follows, m_axis_tready, s_axis_tready)
	`CHK_SAME(a_cfg_always_open, 1'b1, cfg_ready)

endmodule

bind text_cell_alpha_blit tcab_checker u_tcab_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

// ===== bench/tcab_checker.sv =====
`timescale 1ns / 1ps
// Checker for the text cell alpha blit: watches the cell, result and register
// channels, predicts each resulting cell and compares it. Uses tcab_pkg.
module tcab_bench_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [175:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [87:0]  m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	output int           fail_count,
	output int           pending
);
	import tcab_pkg::*;

	// Packed so that the glyph sits in the lowest bits, as on the result bus.
	typedef struct packed {
		logic [31:0] back;
		logic [31:0] fore;
		logic [20:0] glyph;
	} blit_cell_t;

	logic [8:0]  fg_factor;
	logic [8:0]  bg_factor;
	logic        key_on;
	logic [23:0] key_value;
	blit_cell_t  cells_due[$];

	// Source-over blend of one RGBA color with interpolation weight n / 65280.
	function automatic logic [31:0] blend_over(input logic [31:0] dst, input logic [31:0] src,
			input longint unsigned n);
		int unsigned sa, da, oa, s, v;
		longint unsigned s64;
		logic [31:0] res;
		sa = src[7:0];
		da = dst[7:0];
		oa = sa + (da * (255 - sa)) / 255;
		if (oa == 0)
			return dst;
		s64 = (longint'(sa) * n) / 65280;
		s = (s64 > 255) ? 255 : int'(s64);
		res = {24'd0, oa[7:0]};
		for (int sh = 8; sh <= 24; sh += 8) begin
			v = ((src >> sh) & 8'hFF) * s + (((dst >> sh) & 8'hFF) * da * (255 - s)) / 255;
			v = v / oa;
			if (v > 255)
				v = 255;
			res |= v << sh;
		end
		return res;
	endfunction

	function automatic blit_cell_t composite(input logic [175:0] d);
		logic [20:0] sg, dg;
		logic [31:0] sf, sb, df, db;
		longint unsigned fgn, bgn;
		blit_cell_t c;
		sg = d[20:0];
		sf = d[52:21];
		sb = d[84:53];
		dg = d[105:85];
		df = d[137:106];
		db = d[169:138];
		c = '{back: db, fore: df, glyph: dg};
		if (key_on && sb[31:8] == key_value)
			return c;
		fgn = fg_factor * sf[7:0];
		bgn = bg_factor * sb[7:0];
		if (fgn > 65152 && bgn > 65152)
			return '{back: sb, fore: sf, glyph: sg};
		c.back = blend_over(db, sb, bgn);
		if (sg == 32) begin
			c.fore = blend_over(df, sb, bgn);
		end else if (dg == 32) begin
			c.glyph = sg;
			c.fore = blend_over(c.back, sf, fgn);
		end else if (dg == sg) begin
			c.fore = blend_over(df, sf, fgn);
		end else if (fgn < 32640) begin
			c.fore = blend_over(df, c.back, fgn * 2);
		end else begin
			c.glyph = sg;
			c.fore = blend_over(c.back, sf, fgn * 2 - 65280);
		end
		return c;
	endfunction

	assign pending = cells_due.size();

	always @(posedge clk or negedge arst_n) begin
		blit_cell_t want, got;
		if (!arst_n) begin
			fg_factor <= 9'd256;
			bg_factor <= 9'd256;
			key_on <= 1'b0;
			key_value <= 24'd0;
			fail_count <= 0;
			cells_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FG_FACTOR: fg_factor <= cfg_data[8:0];
					REG_BG_FACTOR: bg_factor <= cfg_data[8:0];
					REG_KEY_EN:    key_on <= cfg_data[0];
					REG_KEY_RGB:   key_value <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				cells_due.push_back(composite(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[84:0];
				if (cells_due.size() == 0) begin
					$error("result cell with no cell pair outstanding: %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = cells_due.pop_front();
					if (got.glyph !== want.glyph)
						$error("out_glyph expected %h got %h", want.glyph, got.glyph);
					if (got.fore !== want.fore)
						$error("out_fore expected %h got %h", want.fore, got.fore);
					if (got.back !== want.back)
						$error("out_back expected %h got %h", want.back, got.back);
					if (got !== want)
						fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

// ===== bench/tb_text_cell_alpha_blit.sv =====
`timescale 1ns / 1ps
// Testbench top for the text cell alpha blit: clock, reset, cell and register
// stimulus, output back-pressure and the verdict. Uses tcab_pkg and tcab_bench_checker.
module tb_text_cell_alpha_blit;
	import tcab_pkg::*;

	localparam int PHASES    = 6;
	localparam int PER_PHASE = 270;
	localparam int STALL_MAX = 3000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [87:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [23:0]  cfg_data;
	int           fail_count;
	int           pending;

	// Test controls: steady turns off random idling on both sides, squeeze asks
	// the receiver for one long hold-off, key_now mirrors the key color register.
	logic         steady;
	logic         squeeze;
	logic [23:0]  key_now;

	text_cell_alpha_blit DUT (.*);

	tcab_bench_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset is applied once at the start; every input has a value from time zero.
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FG_FACTOR;
		cfg_data = '0;
		steady = 1'b0;
		squeeze = 1'b0;
		key_now = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// The receiver drops tready at random with a probability of one in ten. A squeeze
	// request holds it low for a long stretch so the pipeline fills and stalls its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				squeeze = 1'b0;
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 10);
			end
		end
	end

	// The watchdog ends the run when no transaction happens on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_MAX) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offers one cell pair after optional idle cycles and holds it until accepted.
	task automatic send_cell(input logic [20:0] sg, input logic [31:0] sf,
			input logic [31:0] sb, input logic [20:0] dg, input logic [31:0] df,
			input logic [31:0] db);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, db, df, dg, sb, sf, sg};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Register writes happen only with the pipeline drained, plus a margin for latency.
	task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd254;
			3: return 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		logic [31:0] v;
		v = $urandom;
		return {v[31:8], pick_alpha()};
	endfunction

	function automatic logic [20:0] pick_glyph(input logic [20:0] other);
		case ($urandom_range(4))
			0: return SPACE_GLYPH;
			1: return 21'($urandom);
			2: return 21'($urandom_range(127));
			default: return other;
		endcase
	endfunction

	// A random cell pair; the source background often carries the key color so
	// the transparent path is taken for those cells whenever the key is enabled.
	task automatic send_random_cell();
		logic [20:0] sg, dg;
		logic [31:0] sb;
		dg = pick_glyph(21'($urandom_range(127)));
		sg = pick_glyph(dg);
		sb = pick_color();
		if ($urandom_range(3) == 0)
			sb[31:8] = key_now;
		send_cell(sg, pick_color(), sb, dg, pick_color(), pick_color());
	endtask

	// Per phase register settings: the factors reach zero, one, and the full
	// nine bits; the key covers both ends of its range.
	logic [8:0]  fg_set [PHASES] = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd300, 9'd255};
	logic [8:0]  bg_set [PHASES] = '{9'd256, 9'd256, 9'd0, 9'd511, 9'd200, 9'd1};
	logic        ke_set [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
	logic [23:0] key_set [PHASES] = '{24'd0, 24'd0, 24'hFFFFFF, 24'h123456, 24'h800001, 24'h0};

	initial begin
		@(posedge arst_n);

		// Directed cells under the reset settings.
		send_cell(21'h41, 32'hFFFFFFFF, 32'h000000FF, 21'h42, 32'h11223344, 32'h55667788);
		send_cell(21'h1FFFFF, 32'h12345600, 32'hABCDEF00, 21'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_cell(21'h41, 32'h80808080, 32'h40404000, 21'h42, 32'h10101000, 32'h20202000);
		send_cell(SPACE_GLYPH, 32'hFFFFFF80, 32'h10203080, 21'h43, 32'h44444444, 32'h99999999);
		send_cell(21'h44, 32'hFF000080, 32'h00FF0040, SPACE_GLYPH, 32'h123456FF, 32'h654321FF);
		send_cell(21'h45, 32'h00FF00C0, 32'h0000FF40, 21'h45, 32'hFF0000FF, 32'h00000080);
		send_cell(21'h46, 32'hFFFFFF20, 32'h80808080, 21'h47, 32'h000000FF, 32'hFFFFFFFF);
		send_cell(21'h46, 32'hFFFFFFC0, 32'h80808080, 21'h47, 32'h000000FF, 32'hFFFFFFFF);
		send_cell(21'h48, 32'hFFFFFFFE, 32'hFFFFFFFF, 21'h49, 32'h00000001, 32'h000000FE);
		send_cell(21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 21'h1FFFFF, 32'h0, 32'h0);
		send_cell(SPACE_GLYPH, 32'h0, 32'h0, SPACE_GLYPH, 32'h0, 32'h0);
		send_cell(21'h10FFFF, 32'hFFFFFF7F, 32'h000000FF, 21'h1, 32'hFFFFFFFF, 32'h00000000);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				write_reg(REG_FG_FACTOR, {15'($urandom), fg_set[p]});
				write_reg(REG_BG_FACTOR, {15'($urandom), bg_set[p]});
				write_reg(REG_KEY_EN, {23'($urandom), ke_set[p]});
				write_reg(REG_KEY_RGB, key_set[p]);
				key_now = key_set[p];
			end
			steady = (p == 2);
			if (p == 3)
				squeeze = 1'b1;
			// A keyed cell and an almost keyed one open each phase.
			send_cell(21'h50, 32'hFFFFFFFF, {key_now, 8'hFF}, 21'h51, 32'h0A0B0C0D, 32'h01020304);
			send_cell(21'h50, 32'hFFFFFFFF, {key_now ^ 24'h1, 8'hFF}, 21'h51, 32'h0, 32'h0);
			for (int i = 0; i < PER_PHASE; i++)
				send_random_cell();
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
